// ===== sv/visible_surface_area_ratio_defines.svh =====
// Assertion macros for the visible surface area ratio block.
// Used by visible_surface_area_ratio.sv; depends on nothing else.
`ifndef VISIBLE_SURFACE_AREA_RATIO_DEFINES_SVH
`define VISIBLE_SURFACE_AREA_RATIO_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VSAR_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("visible surface area ratio check failed");
`define VSAR_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("visible surface area ratio check failed");
`else
`define VSAR_ASSERT_SAME(lbl, clk, rst, pre, post)
`define VSAR_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== sv/vsar_pkg.sv =====
// Types and constants of the visible surface area ratio block.
// Used by visible_surface_area_ratio.sv; depends on nothing else.
`timescale 1ns / 1ps
package vsar_pkg;

   localparam int CoordWidth = 24;
   localparam int AreaWidth  = 56;
   localparam int RatioWidth = 32;

   typedef struct packed {
      logic signed [CoordWidth-1:0] ax;
      logic signed [CoordWidth-1:0] ay;
      logic signed [CoordWidth-1:0] az;
      logic signed [CoordWidth-1:0] bx;
      logic signed [CoordWidth-1:0] by;
      logic signed [CoordWidth-1:0] bz;
      logic signed [CoordWidth-1:0] cx;
      logic signed [CoordWidth-1:0] cy;
      logic signed [CoordWidth-1:0] cz;
      logic                         last_triangle;
   } req_type;

   typedef struct packed {
      logic [RatioWidth-1:0] area_ratio;
      logic                  ratio_error;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_SQR  = 7'b0000100,
      ST_ROOT = 7'b0001000,
      ST_ACC  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

// ===== sv/visible_surface_area_ratio.sv =====
// Visible surface area ratio: triangle area accumulation and ratio division.
// Depends on vsar_pkg.sv and visible_surface_area_ratio_defines.svh.
// A triangle passes acceptance, 6 multiplies, 12 squaring steps, 52 root steps and
// accumulation; a last one adds 32 divide steps (none for a zero total or a saturated
// ratio) and a done state that waits for the output; requests stall until idle again.
// Reset (synchronous, active high) clears the sum, the total and the control.
`timescale 1ns / 1ps
`include "visible_surface_area_ratio_defines.svh"

module visible_surface_area_ratio #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vsar_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vsar_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [55:0]      csr_total_area
);

   // The area in Q24.32 is the square root scaled by 2^(31 - 2F); the factor
   // of one half is folded into that exponent.
   localparam int ShiftExp = 31 - 2 * COORD_FRAC_BITS;
   localparam int ShlAmt   = (ShiftExp > 0) ? ShiftExp : 0;
   localparam int ShrAmt   = (ShiftExp < 0) ? -ShiftExp : 0;

   // Control state.
   vsar_pkg::state_type state_ff, state_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         last_ff, last_in;
   logic [55:0]  total_ff, total_in;
   logic [55:0]  sum_ff, sum_in;
   logic         rsp_valid_ff, rsp_valid_in;
   vsar_pkg::rsp_type rsp_ff, rsp_in;
   vsar_pkg::rsp_type res_ff, res_in;

   // Edge vectors, held for the whole transaction.
   logic signed [24:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [24:0] ux_in, uy_in, uz_in, vx_in, vy_in, vz_in;

   // Cross product: shared multiplier, partial product and magnitude line.
   logic signed [49:0] tmp_ff, tmp_in;
   logic [50:0]  mag_ff [3];
   logic [50:0]  mag_in [3];

   // Squaring and square root.
   logic [101:0] prod_ff, prod_in;
   logic [101:0] ssum_ff, ssum_in;
   logic [103:0] rad_ff, rad_in;
   logic [54:0]  srem_ff, srem_in;
   logic [51:0]  root_ff, root_in;

   // Divider.
   logic [55:0]  drem_ff, drem_in;
   logic [31:0]  nb_ff, nb_in;
   logic [31:0]  qt_ff, qt_in;

   // Combinational helpers.
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] xprod;
   logic signed [50:0] comp;
   logic [50:0]  comp_mag;
   logic [16:0]  slice;
   logic [67:0]  pmul;
   logic [54:0]  r2, trial;
   logic [71:0]  scaled;
   logic [55:0]  area;
   logic [56:0]  sum_add;
   logic [55:0]  sum_new;
   logic [56:0]  dt;
   logic [56:0]  ddiff;
   logic         dge;
   logic         out_free;

   assign req_stall = (state_ff != vsar_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the six cross product terms.
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0: begin mul_a = uy_ff; mul_b = vz_ff; end
         3'd1: begin mul_a = vy_ff; mul_b = uz_ff; end
         3'd2: begin mul_a = vx_ff; mul_b = uz_ff; end
         3'd3: begin mul_a = ux_ff; mul_b = vz_ff; end
         3'd4: begin mul_a = ux_ff; mul_b = vy_ff; end
         3'd5: begin mul_a = vx_ff; mul_b = uy_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign xprod    = mul_a * mul_b;
   assign comp     = 51'(tmp_ff) - 51'(xprod);
   assign comp_mag = comp[50] ? 51'(-comp) : 51'(comp);

   // Squaring works on 17-bit digits of the magnitude, most significant first.
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    slice = mag_ff[0][50:34];
         2'd1:    slice = mag_ff[0][33:17];
         2'd2:    slice = mag_ff[0][16:0];
         default: slice = '0;
      endcase
   end

   assign pmul = 68'(mag_ff[0]) * 68'(slice);

   // One result bit of the square root per cycle.
   assign r2    = {srem_ff[52:0], rad_ff[103:102]};
   assign trial = 55'({root_ff, 2'b01});

   // Area scaling and saturating accumulation.
   assign scaled  = ({20'b0, root_ff} << ShlAmt) >> ShrAmt;
   assign area    = (|scaled[71:56]) ? '1 : scaled[55:0];
   assign sum_add = {1'b0, sum_ff} + {1'b0, area};
   assign sum_new = sum_add[56] ? '1 : sum_add[55:0];

   // One quotient bit of the ratio per cycle.
   assign dt    = {drem_ff, nb_ff[31]};
   assign ddiff = dt - {1'b0, total_ff};
   assign dge   = (dt >= {1'b0, total_ff});

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      ux_in = ux_ff; uy_in = uy_ff; uz_in = uz_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      tmp_in  = tmp_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      ssum_in = ssum_ff;
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      drem_in = drem_ff;
      nb_in   = nb_ff;
      qt_in   = qt_ff;

      if (csr_valid && csr_ready) begin
         total_in = csr_total_area;
      end

      // The output register is emptied by an accepted transaction.
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         vsar_pkg::ST_IDLE: begin
            if (req_valid) begin
               ux_in   = 25'(req_data.bx) - 25'(req_data.ax);
               uy_in   = 25'(req_data.by) - 25'(req_data.ay);
               uz_in   = 25'(req_data.bz) - 25'(req_data.az);
               vx_in   = 25'(req_data.cx) - 25'(req_data.ax);
               vy_in   = 25'(req_data.cy) - 25'(req_data.ay);
               vz_in   = 25'(req_data.cz) - 25'(req_data.az);
               last_in = req_data.last_triangle;
               cnt_in  = '0;
               state_in = vsar_pkg::ST_MUL;
            end
         end
         vsar_pkg::ST_MUL: begin
            if (!cnt_ff[0]) begin
               tmp_in = xprod;
            end else begin
               mag_in[0] = mag_ff[1];
               mag_in[1] = mag_ff[2];
               mag_in[2] = comp_mag;
            end
            if (cnt_ff == 6'd5) begin
               cnt_in   = '0;
               ssum_in  = '0;
               state_in = vsar_pkg::ST_SQR;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         vsar_pkg::ST_SQR: begin
            if (cnt_ff[1:0] == 2'd0) begin
               prod_in = 102'(pmul);
            end else if (cnt_ff[1:0] != 2'd3) begin
               prod_in = (prod_ff << 17) + 102'(pmul);
            end else begin
               ssum_in   = ssum_ff + prod_ff;
               mag_in[0] = mag_ff[1];
               mag_in[1] = mag_ff[2];
               mag_in[2] = '0;
            end
            if (cnt_ff == 6'd11) begin
               rad_in   = {2'b00, ssum_in};
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = vsar_pkg::ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         vsar_pkg::ST_ROOT: begin
            rad_in = rad_ff << 2;
            if (r2 >= trial) begin
               srem_in = r2 - trial;
               root_in = {root_ff[50:0], 1'b1};
            end else begin
               srem_in = r2;
               root_in = {root_ff[50:0], 1'b0};
            end
            if (cnt_ff == 6'd51) begin
               state_in = vsar_pkg::ST_ACC;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         vsar_pkg::ST_ACC: begin
            cnt_in = '0;
            if (!last_ff) begin
               sum_in   = sum_new;
               state_in = vsar_pkg::ST_IDLE;
            end else begin
               sum_in = '0;
               priority if (total_ff == '0) begin
                  res_in.area_ratio  = '0;
                  res_in.ratio_error = 1'b1;
                  state_in = vsar_pkg::ST_DONE;
               end else if ({2'b00, sum_new} >= {total_ff, 2'b00}) begin
                  res_in.area_ratio  = '1;
                  res_in.ratio_error = 1'b0;
                  state_in = vsar_pkg::ST_DONE;
               end else begin
                  drem_in  = {2'b00, sum_new[55:2]};
                  nb_in    = {sum_new[1:0], 30'b0};
                  qt_in    = '0;
                  state_in = vsar_pkg::ST_DIV;
               end
            end
         end
         vsar_pkg::ST_DIV: begin
            drem_in = dge ? ddiff[55:0] : dt[55:0];
            nb_in   = nb_ff << 1;
            qt_in   = {qt_ff[30:0], dge};
            if (cnt_ff == 6'd31) begin
               res_in.area_ratio  = qt_in;
               res_in.ratio_error = 1'b0;
               state_in = vsar_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         vsar_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = vsar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vsar_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vsar_pkg::ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         total_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      res_ff  <= res_in;
      ux_ff   <= ux_in;
      uy_ff   <= uy_in;
      uz_ff   <= uz_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      vz_ff   <= vz_in;
      tmp_ff  <= tmp_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      ssum_ff <= ssum_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      nb_ff   <= nb_in;
      qt_ff   <= qt_in;
   end

   // An accepted transaction always starts the cross product.
   `VSAR_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == vsar_pkg::ST_MUL)
   // A new result only appears after the finishing state.
   `VSAR_ASSERT_SAME(a_result_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == vsar_pkg::ST_DONE)
   // A zero total never carries a non-zero ratio.
   `VSAR_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid_ff && rsp_ff.ratio_error, rsp_ff.area_ratio == 32'd0)

endmodule

// ===== test/vsar_ratio_checker.sv =====
// Checker for the visible surface area ratio block: watches the request, result
// and register channels, predicts each ratio and compares it with the block.
// Depends on vsar_pkg.sv for the transaction types.
`timescale 1ns / 1ps

module vsar_ratio_checker #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  vsar_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  vsar_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [55:0]       csr_total_area,
   output int                mismatch_count,
   output int                pending_count
);

   localparam logic [55:0] SumMax = {56{1'b1}};
   localparam int ScaleShift = 31 - 2 * COORD_FRAC_BITS;

   logic [55:0] total_copy;
   logic [55:0] visible_sum;
   vsar_pkg::rsp_type expected_ratios[$];
   int errors;

   assign mismatch_count = errors;
   assign pending_count  = expected_ratios.size();

   // Half the length of (b - a) x (c - a), in unsigned Q24.32.
   function automatic logic [55:0] triangle_area(vsar_pkg::req_type t);
      logic signed [63:0] ux, uy, uz, vx, vy, vz, c0, c1, c2;
      logic [127:0] m0, m1, m2, sq, root, probe;
      ux = t.bx - t.ax;  uy = t.by - t.ay;  uz = t.bz - t.az;
      vx = t.cx - t.ax;  vy = t.cy - t.ay;  vz = t.cz - t.az;
      c0 = uy * vz - vy * uz;
      c1 = vx * uz - ux * vz;
      c2 = ux * vy - vx * uy;
      m0 = c0 < 0 ? 128'(-c0) : 128'(c0);
      m1 = c1 < 0 ? 128'(-c1) : 128'(c1);
      m2 = c2 < 0 ? 128'(-c2) : 128'(c2);
      sq = m0 * m0 + m1 * m1 + m2 * m2;
      root = 0;
      for (int k = 56; k >= 0; k--) begin
         probe = root | (128'd1 << k);
         if (probe * probe <= sq) begin
            root = probe;
         end
      end
      if (ScaleShift >= 0) begin
         if (root > (128'(SumMax) >> ScaleShift)) begin
            return SumMax;
         end
         return 56'(root << ScaleShift);
      end
      return 56'(root >> (-ScaleShift));
   endfunction

   function automatic vsar_pkg::rsp_type view_ratio(logic [55:0] sum, logic [55:0] total);
      vsar_pkg::rsp_type r;
      logic [127:0] quot;
      r.area_ratio  = '0;
      r.ratio_error = 1'b0;
      if (total == 0) begin
         r.ratio_error = 1'b1;
      end else begin
         quot = 128'(sum) / 128'(total);
         if (quot >= 4) begin
            r.area_ratio = '1;
         end else begin
            r.area_ratio = 32'((128'(sum) << 30) / 128'(total));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      logic [55:0] area;
      vsar_pkg::rsp_type want;
      if (reset) begin
         total_copy  = '0;
         visible_sum = '0;
         expected_ratios.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            total_copy = csr_total_area;
         end
         if (req_valid && !req_stall) begin
            area = triangle_area(req_data);
            visible_sum = (area > SumMax - visible_sum) ? SumMax : visible_sum + area;
            if (req_data.last_triangle) begin
               expected_ratios.insert(expected_ratios.size(),
                  view_ratio(visible_sum, total_copy));
               visible_sum = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_ratios.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transaction, got ratio %h error %b",
                  $time, rsp_data.area_ratio, rsp_data.ratio_error);
            end else begin
               want = expected_ratios.pop_front();
               if (rsp_data.area_ratio !== want.area_ratio) begin
                  errors++;
                  $display("%0t: area_ratio expected %h, got %h",
                     $time, want.area_ratio, rsp_data.area_ratio);
               end
               if (rsp_data.ratio_error !== want.ratio_error) begin
                  errors++;
                  $display("%0t: ratio_error expected %b, got %b",
                     $time, want.ratio_error, rsp_data.ratio_error);
               end
            end
         end
      end
   end

endmodule

// ===== test/tb_visible_surface_area_ratio.sv =====
// Top of the visible surface area ratio testbench: clock, reset, stimulus and verdict.
// Depends on vsar_pkg.sv, visible_surface_area_ratio.sv and vsar_ratio_checker.sv.
`timescale 1ns / 1ps

module tb_visible_surface_area_ratio;

   localparam logic [23:0] CoordMin = 24'h800000;
   localparam logic [23:0] CoordMax = 24'h7FFFFF;

   // Shapes of generated triangles.
   localparam int ShapeFull    = 0;
   localparam int ShapeSmall   = 1;
   localparam int ShapeExtreme = 2;
   localparam int ShapeCube    = 3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   vsar_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   vsar_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [55:0]       csr_total_area;
   int                mismatch_count;
   int                pending_count;

   // Shared between the sender and the receiver processes.
   bit sender_quiet;
   bit receiver_quiet;
   bit hold_pending;

   visible_surface_area_ratio DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_total_area (csr_total_area)
   );

   vsar_ratio_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_total_area (csr_total_area),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // A 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Safety net: a healthy run finishes far inside this time.
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // The receiver draws a random stall, none when quiet, before every result transaction. When asked,
   // it instead holds off for a long stretch so that results back up into the
   // block and the request side stalls.
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (2500) @(posedge clock);
         end else begin
            gap = receiver_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   function automatic logic [23:0] pick_extreme();
      return $urandom_range(0, 1) ? CoordMax : CoordMin;
   endfunction

   function automatic vsar_pkg::req_type make_triangle(int shape, bit last);
      vsar_pkg::req_type t;
      unique case (shape)
         ShapeFull: begin
            t.ax = 24'($urandom);  t.ay = 24'($urandom);  t.az = 24'($urandom);
            t.bx = 24'($urandom);  t.by = 24'($urandom);  t.bz = 24'($urandom);
            t.cx = 24'($urandom);  t.cy = 24'($urandom);  t.cz = 24'($urandom);
         end
         ShapeSmall: begin
            t.ax = 24'($urandom_range(0, 2047) - 1024);
            t.ay = 24'($urandom_range(0, 2047) - 1024);
            t.az = 24'($urandom_range(0, 2047) - 1024);
            t.bx = 24'($urandom_range(0, 2047) - 1024);
            t.by = 24'($urandom_range(0, 2047) - 1024);
            t.bz = 24'($urandom_range(0, 2047) - 1024);
            t.cx = 24'($urandom_range(0, 2047) - 1024);
            t.cy = 24'($urandom_range(0, 2047) - 1024);
            t.cz = 24'($urandom_range(0, 2047) - 1024);
         end
         ShapeExtreme: begin
            t.ax = pick_extreme();  t.ay = pick_extreme();  t.az = pick_extreme();
            t.bx = pick_extreme();  t.by = pick_extreme();  t.bz = pick_extreme();
            t.cx = pick_extreme();  t.cy = pick_extreme();  t.cz = pick_extreme();
         end
         default: begin
            // Corners of the coordinate cube giving about the largest area.
            t.ax = CoordMax;  t.ay = CoordMin;  t.az = CoordMin;
            t.bx = CoordMin;  t.by = CoordMax;  t.bz = CoordMin;
            t.cx = CoordMin;  t.cy = CoordMin;  t.cz = CoordMax;
         end
      endcase
      t.last_triangle = last;
      return t;
   endfunction

   // Offer one triangle after a random gap and wait until it is taken.
   task automatic send_triangle(vsar_pkg::req_type t);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_coords(logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                              logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                              logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                              bit last);
      vsar_pkg::req_type t;
      t = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
      send_triangle(t);
   endtask

   // A run of random views, each a handful of triangles of mixed shape.
   task automatic send_views(int count, int max_len);
      int sent;
      int len;
      int shape;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, max_len);
         for (int i = 0; i < len; i++) begin
            shape = $urandom_range(0, 9);
            shape = (shape < 6) ? ShapeFull : (shape < 8) ? ShapeSmall : ShapeExtreme;
            send_triangle(make_triangle(shape, i == len - 1));
         end
         sent += len;
      end
   endtask

   // Wait until every expected result has arrived and the block has settled,
   // since trailing triangles with no result may still be in progress.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_total(logic [55:0] value);
      csr_valid      <= 1'b1;
      csr_total_area <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_valid      <= 1'b0;
      csr_total_area <= '0;
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      hold_pending   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The total is still zero from reset: every view reports an error.
      send_views(40, 4);
      drain();

      // Directed triangles against a mid-range total.
      write_total(56'h0010_0000_0000_00);
      send_coords('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
      send_coords(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin,
                  CoordMin, CoordMin, CoordMin, 1'b1);
      send_coords(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                  CoordMax, CoordMax, CoordMax, 1'b0);
      send_triangle(make_triangle(ShapeCube, 1'b1));
      send_coords(CoordMin, CoordMin, CoordMin, CoordMax, CoordMin, CoordMin,
                  CoordMin, CoordMax, CoordMin, 1'b1);
      send_coords(CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax,
                  CoordMax, CoordMax, CoordMin, 1'b1);
      // Collinear points and repeated vertices give no area.
      send_coords(24'd0, 24'd0, 24'd0, 24'd100, 24'd200, 24'd300,
                  24'd200, 24'd400, 24'd600, 1'b1);
      send_coords(24'd5, 24'd6, 24'd7, 24'd5, 24'd6, 24'd7, 24'd9, 24'd1, 24'd2, 1'b1);
      // Tiny triangles where the truncation of the area shows.
      send_coords(24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 1'b0);
      send_coords(24'd0, 24'd0, 24'd0, 24'd2, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 1'b0);
      send_coords(24'd0, 24'd0, 24'd0, 24'd3, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 1'b1);
      send_coords(24'h010000, 24'h000000, 24'hFF0000, 24'h000000, 24'h010000,
                  24'h000000, 24'hFFFFFF, 24'h000001, 24'h000000, 1'b1);
      drain();

      // A total of one makes almost every ratio saturate.
      write_total(56'd1);
      send_coords(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
      send_views(120, 5);
      drain();

      // A view long enough to saturate the sum, against the largest total.
      write_total({56{1'b1}});
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      for (int i = 0; i < 320; i++) begin
         send_triangle(make_triangle(ShapeCube, i == 319));
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      send_views(100, 6);
      drain();

      // The receiver holds off while one-triangle views keep coming, so the
      // result register fills and the block stalls its input.
      write_total({8'($urandom_range(16, 63)), 48'(0)} | 56'($urandom));
      hold_pending = 1'b1;
      sender_quiet = 1'b1;
      send_views(60, 1);
      sender_quiet = 1'b0;
      send_views(140, 5);
      drain();

      // An explicit write of zero.
      write_total('0);
      send_views(60, 4);
      drain();

      // Totals across the range, some phases without idling on either side.
      for (int p = 0; p < 6; p++) begin
         unique case (p % 3)
            0: write_total(56'({$urandom, $urandom}));
            1: write_total({4'd0, 4'($urandom_range(1, 15)), 48'({$urandom, $urandom})});
            default: write_total(56'($urandom) << $urandom_range(20, 40));
         endcase
         sender_quiet   = (p == 2);
         receiver_quiet = (p == 2) || (p == 4);
         send_views(100, 6);
         drain();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
